// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker module.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk_i, disabled while rst_ni is low.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Expression that must never be true at a clock edge.
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_CLK(lbl, !(expr), msg)

`endif

// ===== sv/tmtw_pkg.sv =====
// Shared constants, types and opcodes of the text-mode terminal writer.
// No dependencies.
`default_nettype none

package tmtw_pkg;

  localparam int SCREEN_WIDTH  = 80;
  localparam int SCREEN_HEIGHT = 25;
  localparam int TAB_STOP      = 8;   // must stay a power of two
  localparam int CELLS         = SCREEN_WIDTH * SCREEN_HEIGHT;

  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int POS_W   = 12;
  localparam int CHAR_W  = 8;
  localparam int ENTRY_W = 16;
  localparam int ADDR_W  = $clog2(CELLS);

  localparam logic [COL_W-1:0]  COL_MAX   = COL_W'(SCREEN_WIDTH - 1);
  localparam logic [ROW_W-1:0]  ROW_MAX   = ROW_W'(SCREEN_HEIGHT - 1);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(CELLS - 1);

  localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

  localparam logic [7:0] RESET_ATTR = 8'h07;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  // Cursor update and cell access decided for one transaction.
  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              scroll;
    logic              wr_en;
    logic [COL_W-1:0]  wr_col;
    logic [CHAR_W-1:0] wr_char;
    logic [COL_W-1:0]  rd_col;
    logic [ROW_W-1:0]  rd_row;
  } cur_upd_t;

endpackage

`default_nettype wire

// ===== sv/tmtw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tmtw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/tmtw_lin.sv =====
// Shared address unit: row * SCREEN_WIDTH + column.
// Depends on tmtw_pkg.
`default_nettype none

module tmtw_lin
  import tmtw_pkg::*;
(
  input  wire logic [ROW_W-1:0] row_i,
  input  wire logic [COL_W-1:0] col_i,
  output logic      [POS_W-1:0] pos_o
);

  assign pos_o = POS_W'(POS_W'(row_i) * POS_W'(SCREEN_WIDTH) + POS_W'(col_i));

endmodule

`default_nettype wire

// ===== sv/tmtw_cursor.sv =====
// Cursor update logic: control characters, wrap, tab stops, clamping.
// Depends on tmtw_pkg.
`default_nettype none

module tmtw_cursor
  import tmtw_pkg::*;
(
  input  wire logic [1:0]        opcode_i,
  input  wire logic [CHAR_W-1:0] char_i,
  input  wire logic [COL_W-1:0]  col_in_i,
  input  wire logic [ROW_W-1:0]  row_in_i,
  input  wire logic [COL_W-1:0]  cur_col_i,
  input  wire logic [ROW_W-1:0]  cur_row_i,
  output cur_upd_t               upd_o
);

  logic [ROW_W:0]   row_p1;
  logic             row_wrap;
  logic [ROW_W-1:0] nl_row;
  logic [COL_W:0]   col_p1;
  logic [COL_W:0]   tab_nxt;
  logic [COL_W-1:0] col_clamp;
  logic [ROW_W-1:0] row_clamp;

  assign row_p1    = {1'b0, cur_row_i} + (ROW_W+1)'(1);
  assign row_wrap  = row_p1 >= (ROW_W+1)'(SCREEN_HEIGHT);
  assign nl_row    = row_wrap ? ROW_MAX : row_p1[ROW_W-1:0];
  assign col_p1    = {1'b0, cur_col_i} + (COL_W+1)'(1);
  assign tab_nxt   = {1'b0, cur_col_i} - ({1'b0, cur_col_i} % (COL_W+1)'(TAB_STOP))
                     + (COL_W+1)'(TAB_STOP);
  assign col_clamp = (col_in_i > COL_MAX) ? COL_MAX : col_in_i;
  assign row_clamp = (row_in_i > ROW_MAX) ? ROW_MAX : row_in_i;

  always_comb begin
    upd_o         = '0;
    upd_o.col     = cur_col_i;
    upd_o.row     = cur_row_i;
    upd_o.wr_col  = cur_col_i;
    upd_o.wr_char = char_i;
    upd_o.rd_col  = col_clamp;
    upd_o.rd_row  = row_clamp;
    unique case (op_e'(opcode_i))
      OP_PUT: begin
        unique case (char_i)
          CH_NL: begin
            upd_o.col    = '0;
            upd_o.row    = nl_row;
            upd_o.scroll = row_wrap;
          end
          CH_CR: begin
            upd_o.col = '0;
          end
          CH_BS: begin
            if (cur_col_i != '0) begin
              upd_o.col     = cur_col_i - COL_W'(1);
              upd_o.wr_en   = 1'b1;
              upd_o.wr_col  = cur_col_i - COL_W'(1);
              upd_o.wr_char = CH_SPACE;
            end
          end
          CH_TAB: begin
            if (tab_nxt >= (COL_W+1)'(SCREEN_WIDTH)) begin
              upd_o.col    = '0;
              upd_o.row    = nl_row;
              upd_o.scroll = row_wrap;
            end else begin
              upd_o.col = tab_nxt[COL_W-1:0];
            end
          end
          default: begin
            upd_o.wr_en = 1'b1;
            if (col_p1 >= (COL_W+1)'(SCREEN_WIDTH)) begin
              upd_o.col    = '0;
              upd_o.row    = nl_row;
              upd_o.scroll = row_wrap;
            end else begin
              upd_o.col = col_p1[COL_W-1:0];
            end
          end
        endcase
      end
      OP_SET: begin
        upd_o.col = col_clamp;
        upd_o.row = row_clamp;
      end
      OP_CLEAR: begin
        upd_o.col = '0;
        upd_o.row = '0;
      end
      OP_READ: begin
        upd_o.col = cur_col_i;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/text_mode_terminal_writer.sv =====
// Text-mode terminal writer: cell store in RAM, cursor, sequencer for scroll and clear.
// Put (no scroll), set-cursor and read: S_DONE registers the result and reopens input;
// a held output keeps S_DONE waiting. A scroll reads then writes each moved cell in
// S_SCR_RD and S_SCR_WR over the single RAM port pair, then one blank per cycle.
// Clear blanks all cells one per cycle; the result shows in the cycle input reopens.
// After reset the sequencer blanks all 2000 entries, one per cycle, and stalls input.
`default_nettype none

module text_mode_terminal_writer
  import tmtw_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        opcode_i,
  input  wire logic [CHAR_W-1:0] char_code_i,
  input  wire logic [COL_W-1:0]  col_in_i,
  input  wire logic [ROW_W-1:0]  row_in_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [COL_W-1:0]       cursor_col_o,
  output logic [ROW_W-1:0]       cursor_row_o,
  output logic [POS_W-1:0]       cursor_pos_o,
  output logic [ENTRY_W-1:0]     read_entry_o,
  output logic                   scrolled_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [7:0]        cfg_data_i
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCR_RD,
    S_SCR_WR,
    S_FILL,
    S_DONE
  } state_e;

  localparam logic [ADDR_W-1:0] SCR_LAST   = ADDR_W'(CELLS - SCREEN_WIDTH - 1);
  localparam logic [ADDR_W-1:0] BOTTOM_ROW = ADDR_W'(CELLS - SCREEN_WIDTH);

  state_e              state_q;
  logic [ADDR_W-1:0]   ptr_q;
  logic [COL_W-1:0]    cur_col_q;
  logic [ROW_W-1:0]    cur_row_q;
  logic [7:0]          color_q;
  logic [7:0]          fill_attr_q;
  op_e                 op_q;
  logic                scr_q;

  cur_upd_t            upd;
  logic                accept;
  logic [ROW_W-1:0]    lin_row;
  logic [COL_W-1:0]    lin_col;
  logic [POS_W-1:0]    lin_pos;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !in_stall_o;

  tmtw_cursor u_cursor (
    .opcode_i  (opcode_i),
    .char_i    (char_code_i),
    .col_in_i  (col_in_i),
    .row_in_i  (row_in_i),
    .cur_col_i (cur_col_q),
    .cur_row_i (cur_row_q),
    .upd_o     (upd)
  );

  // One address unit serves the write, the read and the cursor position output.
  always_comb begin
    lin_row = cur_row_q;
    lin_col = cur_col_q;
    if (state_q == S_IDLE) begin
      if (op_e'(opcode_i) == OP_READ) begin
        lin_row = upd.rd_row;
        lin_col = upd.rd_col;
      end else begin
        lin_col = upd.wr_col;
      end
    end
  end

  tmtw_lin u_lin (
    .row_i (lin_row),
    .col_i (lin_col),
    .pos_o (lin_pos)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_q;
    ram_wdata = {fill_attr_q, CH_SPACE};
    ram_re    = 1'b0;
    ram_raddr = lin_pos[ADDR_W-1:0];
    unique case (state_q)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = {RESET_ATTR, CH_SPACE};
      end
      S_IDLE: begin
        ram_we    = accept && upd.wr_en;
        ram_waddr = lin_pos[ADDR_W-1:0];
        ram_wdata = {color_q, upd.wr_char};
        ram_re    = accept && (op_e'(opcode_i) == OP_READ);
      end
      S_SCR_RD: begin
        ram_re    = 1'b1;
        ram_raddr = ADDR_W'(ptr_q + ADDR_W'(SCREEN_WIDTH));
      end
      S_SCR_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      S_FILL: begin
        ram_we = 1'b1;
      end
      S_DONE: begin
        ram_we = 1'b0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  tmtw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      ptr_q        <= '0;
      cur_col_q    <= '0;
      cur_row_q    <= '0;
      color_q      <= RESET_ATTR;
      fill_attr_q  <= RESET_ATTR;
      op_q         <= OP_PUT;
      scr_q        <= 1'b0;
      out_valid_o  <= 1'b0;
      cursor_col_o <= '0;
      cursor_row_o <= '0;
      cursor_pos_o <= '0;
      read_entry_o <= '0;
      scrolled_o   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        color_q <= cfg_data_i;
      end
      // S_DONE owns out_valid_o while it hands over a result
      if (out_valid_o && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        S_INIT: begin
          if (ptr_q == ADDR_LAST) begin
            ptr_q   <= '0;
            state_q <= S_IDLE;
          end else begin
            ptr_q <= ptr_q + ADDR_W'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_q      <= op_e'(opcode_i);
            cur_col_q <= upd.col;
            cur_row_q <= upd.row;
            scr_q     <= upd.scroll;
            if (op_e'(opcode_i) == OP_CLEAR) begin
              ptr_q       <= '0;
              fill_attr_q <= color_q;
              state_q     <= S_FILL;
            end else if (upd.scroll) begin
              ptr_q   <= '0;
              state_q <= S_SCR_RD;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_SCR_RD: begin
          state_q <= S_SCR_WR;
        end
        S_SCR_WR: begin
          if (ptr_q == SCR_LAST) begin
            ptr_q       <= BOTTOM_ROW;
            fill_attr_q <= color_q;
            state_q     <= S_FILL;
          end else begin
            ptr_q   <= ptr_q + ADDR_W'(1);
            state_q <= S_SCR_RD;
          end
        end
        S_FILL: begin
          if (ptr_q == ADDR_LAST) begin
            state_q <= S_DONE;
          end else begin
            ptr_q <= ptr_q + ADDR_W'(1);
          end
        end
        S_DONE: begin
          // read data from the RAM holds here since no read is issued
          if (!out_valid_o || !out_stall_i) begin
            out_valid_o  <= 1'b1;
            cursor_col_o <= cur_col_q;
            cursor_row_o <= cur_row_q;
            cursor_pos_o <= lin_pos;
            read_entry_o <= (op_q == OP_READ) ? ram_rdata : '0;
            scrolled_o   <= scr_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/tmtw_checker.sv =====
// Port-level checker for the text-mode terminal writer, bound to the top level.
// Depends on tmtw_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tmtw_checker
  import tmtw_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [COL_W-1:0]  cursor_col_o,
  input wire logic [ROW_W-1:0]  cursor_row_o,
  input wire logic [POS_W-1:0]  cursor_pos_o,
  input wire logic              scrolled_o
);

  logic             off_screen;
  logic [POS_W-1:0] pos_calc;
  logic             at_home;
  logic             accepted;
  logic             out_held;

  assign off_screen = (cursor_col_o > COL_MAX) || (cursor_row_o > ROW_MAX);
  assign pos_calc   = POS_W'(POS_W'(cursor_row_o) * POS_W'(SCREEN_WIDTH)
                      + POS_W'(cursor_col_o));
  assign at_home    = (cursor_row_o == ROW_MAX) && (cursor_col_o == '0);
  assign accepted   = in_valid_i && !in_stall_o;
  assign out_held   = out_valid_o && out_stall_i;

  `ASSERT_NEVER(a_cursor_in_range, out_valid_o && off_screen, "cursor out of screen")
  `ASSERT_CLK(a_pos_linear, out_valid_o |-> (cursor_pos_o == pos_calc), "cursor_pos mismatch")
  `ASSERT_CLK(a_scroll_home, (out_valid_o && scrolled_o) |-> at_home, "scroll left cursor off")
  `ASSERT_CLK(a_busy_after_accept, accepted |=> in_stall_o, "accepted without going busy")
  `ASSERT_CLK(a_out_hold, out_held |=> (out_valid_o && $stable(cursor_pos_o)), "stalled result changed")

endmodule

bind text_mode_terminal_writer tmtw_checker u_tmtw_checker (.*);

`default_nettype wire
